>>> design/bch_15_7_decoder_defines.svh
// assertion macros for the bch(15,7) decoder
`ifndef BCH_15_7_DECODER_DEFINES_SVH
`define BCH_15_7_DECODER_DEFINES_SVH

// implication checked on every edge outside reset
`define BCH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bch check failed");

// next-cycle implication outside reset
`define BCH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bch check failed");

`endif

>>> design/bch_pkg.sv
package bch_pkg;
  localparam int unsigned N = 15;
  localparam int unsigned K = 7;

  typedef logic [3:0] gf_t;
  typedef logic [N-1:0] word_t;
  typedef logic [3:0] cnt_t;

  // multiply by alpha: p(x) = x^4 + x + 1
  function automatic gf_t gf_mul_a(input gf_t a);
    gf_mul_a = {a[2:0], 1'b0} ^ (a[3] ? 4'b0011 : 4'b0000);
  endfunction

  // multiply by alpha^3
  function automatic gf_t gf_mul_a3(input gf_t a);
    gf_mul_a3 = gf_mul_a(gf_mul_a(gf_mul_a(a)));
  endfunction

  // full gf(16) multiply, 4 shift-add steps
  function automatic gf_t gf_mul(input gf_t a, input gf_t b);
    gf_t acc;
    gf_t x;
    acc = '0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc = acc ^ x;
      x = gf_mul_a(x);
    end
    gf_mul = acc;
  endfunction

  // inverse table
  function automatic gf_t gf_inv(input gf_t a);
    case (a)
      4'd1: gf_inv = 4'd1;   4'd2: gf_inv = 4'd9;   4'd3: gf_inv = 4'd14;
      4'd4: gf_inv = 4'd13;  4'd5: gf_inv = 4'd11;  4'd6: gf_inv = 4'd7;
      4'd7: gf_inv = 4'd6;   4'd8: gf_inv = 4'd15;  4'd9: gf_inv = 4'd2;
      4'd10: gf_inv = 4'd12; 4'd11: gf_inv = 4'd5;  4'd12: gf_inv = 4'd10;
      4'd13: gf_inv = 4'd4;  4'd14: gf_inv = 4'd3;  4'd15: gf_inv = 4'd8;
      default: gf_inv = 4'd0;
    endcase
  endfunction
endpackage

>>> design/bch_syn.sv
module bch_syn (
  input  logic         clk,
  input  logic         start,
  input  bch_pkg::word_t word,
  input  logic         shift_en,
  output bch_pkg::gf_t s1,
  output bch_pkg::gf_t s3
);
  import bch_pkg::*;

  word_t sh_r;
  gf_t   s1_r;
  gf_t   s3_r;

  // horner over bits msb first: s = s*a^j + r_i
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r <= word;
      s1_r <= '0;
      s3_r <= '0;
    end else if (shift_en) begin
      sh_r <= {sh_r[N-2:0], 1'b0};
      s1_r <= gf_mul_a(s1_r) ^ {3'b000, sh_r[N-1]};
      s3_r <= gf_mul_a3(s3_r) ^ {3'b000, sh_r[N-1]};
    end
  end

  assign s1 = s1_r;
  assign s3 = s3_r;
endmodule

>>> design/bch_15_7_decoder.sv
// bch(15,7) t=2 hard-decision decoder, bit-serial
// sequence: syndrome shifts (ST_SYN), locator steps (ST_L1, ST_L2), c2 load then chien search
// (ST_CHIEN), output load (ST_OUT)
// one item in flight at a time
// reset: synchronous active-low rst_n clears control, outputs go invalid, input stalls
`include "bch_15_7_decoder_defines.svh"
module bch_15_7_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [14:0]          in_received_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [14:0]          out_corrected_word,
  output logic [6:0]           out_info_bits,
  output logic [1:0]           out_corrections_made,
  output logic                 out_syndrome_nonzero
);
  import bch_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_SYN, ST_L1, ST_L2, ST_CHIEN, ST_OUT} state_t;

  state_t state_r;
  cnt_t   cnt_r;
  word_t  word_r;
  gf_t    c1_r, t_r, d_r;
  gf_t    x1_r, x2_r;   // c1*a^i and c2*a^2i running terms
  logic [1:0] flips_r;
  logic   nz_r;
  logic   out_valid_r;
  word_t  mask_r;       // one-hot at position (15-i) mod 15

  gf_t s1, s3;
  logic start;
  logic in_xfer, out_xfer;

  assign in_stall = !rst_n || (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign start    = in_xfer;

  // syndrome shift register gets its own boundary
  bch_syn u_syn (
    .clk(clk), .start(start), .word(in_received_word),
    .shift_en(state_r == ST_SYN), .s1(s1), .s3(s3)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // output drains unless a new result is loaded this cycle
      if (out_xfer && state_r != ST_OUT) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            word_r  <= in_received_word;
            cnt_r   <= '0;
            state_r <= ST_SYN;
          end
        end
        ST_SYN: begin
          // shifts the syndrome register once per bit of the word
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(N - 1)) state_r <= ST_L1;
        end
        ST_L1: begin
          // t = s1^2 then d = s3 + s1^3
          t_r     <= gf_mul(s1, s1);
          nz_r    <= (s1 != '0) || (s3 != '0);
          state_r <= ST_L2;
        end
        ST_L2: begin
          d_r     <= s3 ^ gf_mul(t_r, s1);
          c1_r    <= s1;
          state_r <= ST_CHIEN;
          cnt_r   <= '0;
          flips_r <= '0;
          mask_r  <= word_t'(1);
          x1_r    <= s1;
          x2_r    <= '0;  // set on first chien cycle
        end
        ST_CHIEN: begin
          // first cycle computes c2 = d/s1; later cycles test alpha^i
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(N)) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_xfer) begin
            out_valid_r          <= 1'b1;
            out_corrected_word   <= word_r;
            out_info_bits        <= word_r[N-1:N-K];
            out_corrections_made <= flips_r;
            out_syndrome_nonzero <= nz_r;
            state_r              <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // chien datapath: cnt 0 loads c2, cnt 1..15 evaluate alpha^(cnt-1)
      if (state_r == ST_CHIEN) begin
        if (cnt_r == '0) begin
          x2_r <= gf_mul(d_r, gf_inv(c1_r));
        end else begin
          if (c1_r != '0 && flips_r != 2'd2 && ((4'd1 ^ x1_r ^ x2_r) == '0)) begin
            word_r  <= word_r ^ mask_r;
            flips_r <= flips_r + 2'd1;
          end
          x1_r   <= gf_mul_a(x1_r);
          x2_r   <= gf_mul_a(gf_mul_a(x2_r));
          // position (15-i) mod 15: 0, 14, 13, ...
          mask_r <= (cnt_r == 4'd1) ? word_t'(1) << (N - 1) : mask_r >> 1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;

  `BCH_ASSERT_IMPL(a_stall_busy, state_r != ST_IDLE, in_stall)
  `BCH_ASSERT_IMPL(a_flips_range, out_valid_r, out_corrections_made != 2'd3)
  `BCH_ASSERT_NEXT(a_hold, out_valid_r && out_stall, out_valid_r && $stable(out_corrected_word))
endmodule

>>> bench/tb.sv
module tb;
  import bch_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [14:0] in_received_word;
  logic        out_valid;
  logic        out_stall;
  logic [14:0] out_corrected_word;
  logic [6:0]  out_info_bits;
  logic [1:0]  out_corrections_made;
  logic        out_syndrome_nonzero;

  bch_15_7_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_received_word(in_received_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_corrected_word(out_corrected_word), .out_info_bits(out_info_bits),
    .out_corrections_made(out_corrections_made),
    .out_syndrome_nonzero(out_syndrome_nonzero)
  );

  // one decoded word as the block should report it
  typedef struct packed {
    logic [14:0] word;
    logic [6:0]  info;
    logic [1:0]  flips;
    logic        nz;
  } decode_t;

  // directed row: known expectation only where has_exp is set
  typedef struct {
    logic [14:0] rx;
    bit          has_exp;
    decode_t     exp;
  } vec_t;

  localparam int LIMIT = 1500000;

  // idling modes
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  decode_t    decode_q[$];
  int         mismatches;
  int         fails;
  int         cycles;
  idle_mode_t mode;
  bit         hold_off;
  bit         hold_req;
  logic [3:0] alpha_pow[15];
  logic [3:0] alpha_log[16];

  // gf(16) helpers built from the primitive polynomial x^4 + x + 1
  function automatic logic [3:0] fmul(logic [3:0] a, logic [3:0] b);
    if (a == 0 || b == 0) return 4'd0;
    return alpha_pow[(alpha_log[a] + alpha_log[b]) % 15];
  endfunction

  function automatic logic [3:0] syn(logic [14:0] w, int j);
    logic [3:0] s;
    s = 0;
    for (int i = 0; i < 15; i++) if (w[i]) s ^= alpha_pow[(i * j) % 15];
    return s;
  endfunction

  // berlekamp locator then chien search, stopping after two roots
  function automatic decode_t bch_decode(logic [14:0] rx);
    decode_t    r;
    logic [3:0] s1, s3, d, c1, c2, x, v;
    logic [14:0] w;
    int         nf;
    w = rx;
    nf = 0;
    s1 = syn(rx, 1);
    s3 = syn(rx, 3);
    if (s1 != 0) begin
      d = s3 ^ fmul(s1, fmul(s1, s1));
      c1 = s1;
      c2 = (d == 0) ? 4'd0 : alpha_pow[(alpha_log[d] + 15 - alpha_log[s1]) % 15];
      for (int i = 0; i < 15 && nf < 2; i++) begin
        x = alpha_pow[i];
        v = 4'd1 ^ fmul(c1, x) ^ fmul(c2, fmul(x, x));
        if (v == 0) begin
          w[(15 - i) % 15] = ~w[(15 - i) % 15];
          nf++;
        end
      end
    end
    r.word = w;
    r.info = w[14:8];
    r.flips = nf[1:0];
    r.nz = (s1 != 0) || (s3 != 0);
    return r;
  endfunction

  // systematic encode: remainder of m(x) x^8 by g(x) = 1+x^4+x^6+x^7+x^8
  function automatic logic [14:0] encode(logic [6:0] m);
    logic [14:0] r;
    r = {m, 8'd0};
    for (int i = 14; i >= 8; i--) if (r[i]) r ^= (15'h1D1 << (i - 8));
    return {m, r[7:0]};
  endfunction

  // random flip pattern of up to n bits
  function automatic logic [14:0] err_pat(int n);
    logic [14:0] e;
    e = 0;
    for (int k = 0; k < n; k++) e[$urandom_range(14, 0)] = 1'b1;
    return e;
  endfunction

  // idle percentage for the current mode
  function automatic int idle_pct();
    return (mode == IDLE_BOTH) ? 23 : 53;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // gf tables
  initial begin
    logic [3:0] a;
    a = 4'd1;
    alpha_log[0] = 0;
    for (int i = 0; i < 15; i++) begin
      alpha_pow[i] = a;
      alpha_log[a] = i[3:0];
      a = {a[2:0], 1'b0} ^ (a[3] ? 4'b0011 : 4'b0000);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall driven at the falling edge
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else if (mode == IDLE_RECV || mode == IDLE_BOTH)
      out_stall <= ($urandom_range(99, 0) < idle_pct());
    else out_stall <= 1'b0;
  end

  // long receiver hold-off, counted here
  initial begin
    hold_off = 0;
    wait (hold_req);
    @(negedge clk);
    hold_off = 1;
    repeat (400) @(negedge clk);
    hold_off = 0;
  end

  // result checking at the rising edge
  always @(posedge clk) begin
    decode_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_corrected_word, out_info_bits, out_corrections_made,
              out_syndrome_nonzero};
      if (decode_q.size() == 0) begin
        fails++;
        if (mismatches < 10) $display("unexpected result %h", got);
        mismatches++;
      end else begin
        want = decode_q.pop_front();
        if (got !== want) begin
          fails++;
          if (mismatches < 10)
            $display("mismatch: exp word %h info %h n %0d nz %b, %s %h info %h n %0d nz %b",
                     want.word, want.info, want.flips, want.nz, "got word",
                     got.word, got.info, got.flips, got.nz);
          mismatches++;
        end
      end
    end
  end

  // one input transfer; expectation queued at acceptance
  task automatic send_word(logic [14:0] rx, decode_t exp);
    if (mode == IDLE_SEND || mode == IDLE_BOTH)
      while ($urandom_range(99, 0) < idle_pct()) begin
        in_valid <= 1'b0;
        in_received_word <= 15'($urandom);
        @(negedge clk);
      end
    in_valid <= 1'b1;
    in_received_word <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_q = {decode_q, exp};
    @(negedge clk);
  endtask

  // stop offering, then wait for every expected result to drain
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (decode_q.size() != 0) @(negedge clk);
  endtask

  // random word: mostly codewords with zero to three flips, rest noise
  function automatic logic [14:0] rand_word();
    int sel;
    sel = $urandom_range(9, 0);
    if (sel < 8) return encode(7'($urandom)) ^ err_pat(sel % 4);
    return 15'($urandom);
  endfunction

  vec_t vecs[16];

  initial begin
    decode_t e;
    in_valid = 0;
    in_received_word = 0;
    rst_n = 0;
    mode = IDLE_NONE;
    hold_req = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed table: zero word, all ones, single and double flips, >t errors
    vecs = '{
      '{15'h0000, 1, '{15'h0000, 7'h00, 2'd0, 1'b0}},
      '{15'h7FFF, 1, '{15'h7FFF, 7'h7F, 2'd0, 1'b0}},
      '{15'h0001, 1, '{15'h0000, 7'h00, 2'd1, 1'b1}},
      '{15'h4000, 1, '{15'h0000, 7'h00, 2'd1, 1'b1}},
      '{15'h4001, 1, '{15'h0000, 7'h00, 2'd2, 1'b1}},
      '{15'h7FFE, 1, '{15'h7FFF, 7'h7F, 2'd1, 1'b1}},
      '{15'h3FFE, 1, '{15'h7FFF, 7'h7F, 2'd2, 1'b1}},
      '{encode(7'h55), 0, '0},
      '{encode(7'h2A) ^ 15'h0100, 0, '0},
      '{encode(7'h13) ^ 15'h0811, 0, '0},
      '{15'h0007, 0, '0},
      '{15'h1111, 0, '0},
      '{15'h5555, 0, '0},
      '{15'h2AAA, 0, '0},
      // s1 zero with s3 nonzero: bits 0, 5, 10 give s1 = 1 ^ a^5 ^ a^10 = 0
      '{15'h0421, 0, '0},
      '{15'h001F, 0, '0}
    };
    foreach (vecs[i]) begin
      e = vecs[i].has_exp ? vecs[i].exp : bch_decode(vecs[i].rx);
      send_word(vecs[i].rx, e);
    end
    drain();

    // random phases across idling modes
    for (int ph = 0; ph < 4; ph++) begin
      mode = idle_mode_t'(ph);
      for (int n = 0; n < 410; n++) begin
        logic [14:0] w;
        w = rand_word();
        if (ph == 1 && n == 100) hold_req = 1;
        // sender pauses until everything is back
        if (ph == 2 && n == 200) drain();
        send_word(w, bch_decode(w));
      end
    end
    mode = IDLE_NONE;

    drain();
    repeat (60) @(negedge clk);
    if (fails == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

>>> bch_15_7_decoder.f
+incdir+design
design/bch_pkg.sv
design/bch_syn.sv
design/bch_15_7_decoder.sv
bench/tb.sv
